@@ rtl/ppel_pkg.sv @@
// types, codes and character classes for the preprocessor expression lexer
package ppel_pkg;

	typedef enum logic [4:0] {
		ST_INIT,
		ST_IDENT,
		ST_IDENT2,
		ST_NUM0,
		ST_0X,
		ST_DEC,
		ST_OCT,
		ST_HEX,
		ST_POST1,
		ST_POST2,
		ST_VBAR,
		ST_AND,
		ST_NOT,
		ST_EQ,
		ST_ANGLE,
		ST_ADD,
		ST_SUB,
		ST_STRING,
		ST_ESC,
		ST_STRHEX
	} lex_state_t;

	typedef enum logic [2:0] {
		KIND_OP,
		KIND_IDENT,
		KIND_MACRO,
		KIND_NUMBER,
		KIND_STRING,
		KIND_CHAR,
		KIND_EOL,
		KIND_ERROR
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE,
		ERR_DIGIT89,
		ERR_BARE_0X,
		ERR_INC,
		ERR_DEC,
		ERR_UNTERM
	} err_t;

	typedef enum logic [1:0] {
		BASE_DEC,
		BASE_OCT,
		BASE_HEX
	} base_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] value;
		logic [7:0]  op_first;
		logic [7:0]  op_second;
		logic [7:0]  length;
		err_t        error_code;
		logic        last;
	} res_t;

	function automatic logic is_eol(input logic [7:0] c);
		return c == 8'd0 || c == 8'd10;
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return c == 8'd32 || c == 8'd9 || c == 8'd11 || c == 8'd12 || c == 8'd13;
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_ident(input logic [7:0] c);
		return is_alpha(c) || is_digit(c) || c == "_";
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	function automatic logic is_l(input logic [7:0] c);
		return c == "l" || c == "L";
	endfunction

	function automatic logic is_u(input logic [7:0] c);
		return c == "u" || c == "U";
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [7:0] d;
		if (is_digit(c)) d = c - "0";
		else if (c >= "a" && c <= "f") d = c - "a" + 8'd10;
		else d = c - "A" + 8'd10;
		return d[3:0];
	endfunction

	function automatic res_t mk_res(input kind_t k, input logic [31:0] v,
			input logic [7:0] a, input logic [7:0] b, input logic [7:0] len, input err_t e);
		res_t r;
		r.kind       = k;
		r.value      = v;
		r.op_first   = a;
		r.op_second  = b;
		r.length     = len;
		r.error_code = e;
		r.last       = 1'b0;
		return r;
	endfunction

endpackage

@@ rtl/preprocessor_expression_lexer.sv @@
// preprocessor expression lexer: one character in, up to two tokens out
// - s_axis carries one character per item (tdata[7:0]) and the sharp mode
//   flag (tdata[8]); code 0 or 10 ends the line and yields an end-of-line token
// - m_axis carries tokens: tuser is the kind, tdata packs value, operator
//   characters, length and error code; tlast marks the final token caused by
//   one input character (a character that ends a token and starts another
//   gives two tokens)
// - an item is registered in the input register, lexed once the queue has
//   room for two tokens and written into a 4-entry result queue, whose head
//   drives m_axis
// - throughput: one character per cycle while the queue has room for two
//   tokens; the queue drains one token per cycle while the receiver is ready,
//   so over a long run the extra token of a two-token character slows the input
// - the lexer takes a registered character only when the queue has room for
//   two tokens; when the receiver stalls the queue fills and tready falls,
//   nothing is dropped
// - reset empties the queue and the input register and puts the lexer in its
//   initial state (accumulator and length zero, last plain char all ones)
// - MAX_TOKEN_LEN sets the length counter; lengths saturate at it and at 255
module preprocessor_expression_lexer #(
	parameter int MAX_TOKEN_LEN = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // ch [7:0], get_sharp [8], zero [15:9]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // value [31:0], op_first [39:32],
	                                    // op_second [47:40], length [55:48],
	                                    // error_code [58:56], zero [63:59]
	output logic [2:0]  m_axis_tuser,   // kind [2:0]
	output logic        m_axis_tlast    // last
);
	import ppel_pkg::*;

	localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	// input register
	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       sharp_s1;
	logic       fire_s1;

	// lexer state
	lex_state_t       st_q, st_n;
	logic [31:0]      acc_q, acc_n;
	logic [LEN_W-1:0] len_q, len_n;
	logic             qdbl_q, qdbl_n;
	logic [7:0]       lpc_q, lpc_n;
	logic             sharp_seen_q, sharp_seen_n;
	logic [7:0]       angle_q, angle_n;
	base_t            base_q, base_n;

	// tokens from the current character
	res_t res_a, res_b;
	logic vld_a, vld_b;
	logic redo;

	// result queue
	res_t              q_mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QPTR_W:0]   cnt_q;
	logic              pop;
	res_t              push0, push1;
	logic [1:0]        push_n;
	res_t              head;

	function automatic logic [7:0] sat_len(input logic [LEN_W-1:0] l);
		logic [LEN_W+7:0] w;
		w = (LEN_W + 8)'(l);
		return (|w[LEN_W+7:8]) ? 8'hFF : w[7:0];
	endfunction

	assign fire_s1       = valid_s1 && (cnt_q <= (QPTR_W + 1)'(QDEPTH - 2));
	assign s_axis_tready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			ch_s1    <= s_axis_tdata[7:0];
			sharp_s1 <= s_axis_tdata[8];
		end
	end

	// next state and token logic: continue the open token, then, if the
	// character ended it or none was open, start a new one with it
	always_comb begin
		logic [31:0] mult;
		logic [3:0]  digit;
		logic [7:0]  c;
		logic [31:0] cval;

		c            = ch_s1;
		st_n         = st_q;
		acc_n        = acc_q;
		len_n        = len_q;
		qdbl_n       = qdbl_q;
		lpc_n        = lpc_q;
		sharp_seen_n = sharp_seen_q;
		angle_n      = angle_q;
		base_n       = base_q;
		res_a        = mk_res(KIND_OP, 32'd0, 8'd0, 8'd0, 8'd0, ERR_NONE);
		res_b        = res_a;
		vld_a        = 1'b0;
		vld_b        = 1'b0;
		redo         = 1'b0;
		digit        = 4'd0;
		mult         = 32'd0;
		cval         = {{24{lpc_q[7]}}, lpc_q};

		// continue the open token
		case (st_q)
			ST_INIT: begin
				redo = 1'b1;
			end
			ST_IDENT: begin
				if (is_ident(c)) begin
					if (len_n < LEN_W'(MAX_TOKEN_LEN)) len_n = len_n + LEN_W'(1);
				end else begin
					res_a = mk_res(KIND_IDENT, 32'd0, 8'd0, 8'd0, sat_len(len_n), ERR_NONE);
					vld_a = 1'b1;
					redo  = 1'b1;
				end
			end
			ST_IDENT2: begin
				if (is_blank(c)) begin
					// blanks inside a joined identifier are dropped
				end else if (is_ident(c) || c == "#") begin
					if (c == "#") sharp_seen_n = 1'b1;
					if (len_n < LEN_W'(MAX_TOKEN_LEN)) len_n = len_n + LEN_W'(1);
				end else begin
					res_a = mk_res(sharp_seen_q ? KIND_MACRO : KIND_IDENT, 32'd0, 8'd0, 8'd0,
						sat_len(len_n), ERR_NONE);
					vld_a = 1'b1;
					redo  = 1'b1;
				end
			end
			ST_NUM0: begin
				if (c == "x" || c == "X") begin
					if (len_n < LEN_W'(MAX_TOKEN_LEN)) len_n = len_n + LEN_W'(1);
					st_n = ST_0X;
				end else if (c >= "0" && c <= "7") begin
					base_n = BASE_OCT;
					digit  = c[3:0];
					st_n   = ST_OCT;
				end else if (c == "8" || c == "9") begin
					res_a = mk_res(KIND_ERROR, 32'd0, 8'd0, 8'd0, 8'd0, ERR_DIGIT89);
					vld_a = 1'b1;
				end else begin
					res_a = mk_res(KIND_NUMBER, acc_q, 8'd0, 8'd0, sat_len(len_n), ERR_NONE);
					vld_a = 1'b1;
					redo  = 1'b1;
				end
			end
			ST_OCT: begin
				if (c >= "0" && c <= "7") begin
					digit = c[3:0];
				end else begin
					res_a = mk_res(KIND_NUMBER, acc_q, 8'd0, 8'd0, sat_len(len_n), ERR_NONE);
					vld_a = 1'b1;
					redo  = 1'b1;
				end
			end
			ST_0X: begin
				if (is_hex(c)) begin
					base_n = BASE_HEX;
					digit  = hex_val(c);
					st_n   = ST_HEX;
				end else begin
					// bad character is consumed, an end of line is seen again
					res_a = mk_res(KIND_ERROR, 32'd0, 8'd0, 8'd0, 8'd0, ERR_BARE_0X);
					vld_a = 1'b1;
					redo  = is_eol(c);
				end
			end
			ST_HEX, ST_DEC: begin
				if ((st_q == ST_HEX) ? is_hex(c) : is_digit(c)) begin
					digit = hex_val(c);
				end else if (is_u(c)) begin
					st_n = ST_POST1;
				end else if (is_l(c)) begin
					st_n = ST_POST2;
				end else begin
					res_a = mk_res(KIND_NUMBER, acc_q, 8'd0, 8'd0, sat_len(len_n), ERR_NONE);
					vld_a = 1'b1;
					redo  = 1'b1;
				end
			end
			ST_POST1: begin
				if (is_l(c)) begin
					st_n = ST_POST2;
				end else begin
					res_a = mk_res(KIND_NUMBER, acc_q, 8'd0, 8'd0, sat_len(len_n), ERR_NONE);
					vld_a = 1'b1;
					redo  = 1'b1;
				end
			end
			ST_POST2: begin
				// a second l is swallowed, anything else starts a token
				res_a = mk_res(KIND_NUMBER, acc_q, 8'd0, 8'd0, sat_len(len_n), ERR_NONE);
				vld_a = 1'b1;
				redo  = !is_l(c);
			end
			ST_VBAR, ST_AND, ST_NOT, ST_EQ, ST_ANGLE: begin
				logic [7:0] op;
				logic       pair;
				case (st_q)
					ST_VBAR: begin op = "|"; pair = (c == "|"); end
					ST_AND: begin op = "&"; pair = (c == "&"); end
					ST_NOT: begin op = "!"; pair = (c == "="); end
					ST_EQ: begin op = "="; pair = (c == "="); end
					default: begin op = angle_q; pair = (c == "=") || (c == angle_q); end
				endcase
				vld_a = 1'b1;
				if (pair) begin
					res_a = mk_res(KIND_OP, 32'd0, op, c, 8'd2, ERR_NONE);
				end else begin
					res_a = mk_res(KIND_OP, 32'd0, op, 8'd0, 8'd1, ERR_NONE);
					redo  = 1'b1;
				end
			end
			ST_ADD, ST_SUB: begin
				logic [7:0] op;
				op    = (st_q == ST_ADD) ? "+" : "-";
				vld_a = 1'b1;
				if (c == op) begin
					res_a = mk_res(KIND_ERROR, 32'd0, 8'd0, 8'd0, 8'd0,
						(st_q == ST_ADD) ? ERR_INC : ERR_DEC);
				end else begin
					res_a = mk_res(KIND_OP, 32'd0, op, 8'd0, 8'd1, ERR_NONE);
					redo  = 1'b1;
				end
			end
			ST_STRING, ST_ESC, ST_STRHEX: begin
				if (is_eol(c)) begin
					res_a = mk_res(KIND_ERROR, 32'd0, 8'd0, 8'd0, 8'd0, ERR_UNTERM);
					vld_a = 1'b1;
					redo  = 1'b1;
				end else if (st_q == ST_ESC) begin
					if (len_n < LEN_W'(MAX_TOKEN_LEN)) len_n = len_n + LEN_W'(1);
					st_n = (c == "x" || c == "X") ? ST_STRHEX : ST_STRING;
				end else if (st_q == ST_STRHEX && is_hex(c)) begin
					if (len_n < LEN_W'(MAX_TOKEN_LEN)) len_n = len_n + LEN_W'(1);
				end else begin
					// ordinary string character, may close the literal
					st_n = ST_STRING;
					if (len_n < LEN_W'(MAX_TOKEN_LEN)) len_n = len_n + LEN_W'(1);
					if (c == "\"") begin
						if (qdbl_q) begin
							res_a = mk_res(KIND_STRING, 32'd0, 8'd0, 8'd0, sat_len(len_n),
								ERR_NONE);
							vld_a = 1'b1;
						end
					end else if (c == "'") begin
						if (!qdbl_q) begin
							res_a = mk_res(KIND_CHAR, cval, 8'd0, 8'd0, sat_len(len_n),
								ERR_NONE);
							vld_a = 1'b1;
						end
					end else if (c == "\\") begin
						st_n = ST_ESC;
					end else begin
						lpc_n = c;
					end
				end
			end
			default: begin
				redo = 1'b1;
			end
		endcase

		// digit accumulate, modulo 2^32
		if (st_q == ST_NUM0 || st_q == ST_OCT || st_q == ST_0X || st_q == ST_HEX
				|| st_q == ST_DEC) begin
			if (!vld_a && st_n != ST_0X && st_n != ST_POST1 && st_n != ST_POST2) begin
				case (base_n)
					BASE_HEX: mult = acc_n << 4;
					BASE_OCT: mult = acc_n << 3;
					default:  mult = (acc_n << 3) + (acc_n << 1);
				endcase
				acc_n = mult + {28'd0, digit};
				if (len_n < LEN_W'(MAX_TOKEN_LEN)) len_n = len_n + LEN_W'(1);
			end
		end

		if (vld_a || redo) st_n = ST_INIT;

		// start a token with this character
		if (redo) begin
			if (is_eol(c)) begin
				res_b = mk_res(KIND_EOL, 32'd0, 8'd0, 8'd0, 8'd0, ERR_NONE);
				vld_b = 1'b1;
			end else if (!is_blank(c)) begin
				len_n = LEN_W'(0);
				acc_n = 32'd0;
				if (is_alpha(c) || c == "_" || c == "#") begin
					len_n        = LEN_W'(1);
					sharp_seen_n = (c == "#");
					st_n         = sharp_s1 ? ST_IDENT2 : ST_IDENT;
				end else if (c == "0") begin
					len_n  = LEN_W'(1);
					base_n = BASE_DEC;
					st_n   = ST_NUM0;
				end else if (is_digit(c)) begin
					len_n  = LEN_W'(1);
					base_n = BASE_DEC;
					acc_n  = {28'd0, c[3:0]};
					st_n   = ST_DEC;
				end else if (c == "|") begin
					st_n = ST_VBAR;
				end else if (c == "&") begin
					st_n = ST_AND;
				end else if (c == "!") begin
					st_n = ST_NOT;
				end else if (c == "=") begin
					st_n = ST_EQ;
				end else if (c == "<" || c == ">") begin
					angle_n = c;
					st_n    = ST_ANGLE;
				end else if (c == "+") begin
					st_n = ST_ADD;
				end else if (c == "-") begin
					st_n = ST_SUB;
				end else if (c == "\"" || c == "'") begin
					len_n  = LEN_W'(1);
					qdbl_n = (c == "\"");
					lpc_n  = 8'hFF;
					st_n   = ST_STRING;
				end else begin
					// anything else is a one-character operator
					res_b = mk_res(KIND_OP, 32'd0, c, 8'd0, 8'd1, ERR_NONE);
					vld_b = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_INIT;
			acc_q        <= 32'd0;
			len_q        <= LEN_W'(0);
			qdbl_q       <= 1'b0;
			lpc_q        <= 8'hFF;
			sharp_seen_q <= 1'b0;
			angle_q      <= 8'd0;
			base_q       <= BASE_DEC;
		end else if (fire_s1) begin
			st_q         <= st_n;
			acc_q        <= acc_n;
			len_q        <= len_n;
			qdbl_q       <= qdbl_n;
			lpc_q        <= lpc_n;
			sharp_seen_q <= sharp_seen_n;
			angle_q      <= angle_n;
			base_q       <= base_n;
		end
	end

	// order the tokens and mark the final one
	always_comb begin
		push0      = vld_a ? res_a : res_b;
		push0.last = !(vld_a && vld_b);
		push1      = res_b;
		push1.last = 1'b1;
		if (!fire_s1) push_n = 2'd0;
		else push_n = 2'(vld_a) + 2'(vld_b);
	end

	assign pop = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + QPTR_W'(push_n);
			rd_q  <= rd_q + QPTR_W'(pop);
			cnt_q <= cnt_q + (QPTR_W + 1)'(push_n) - (QPTR_W + 1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) q_mem_q[wr_q] <= push0;
		if (push_n == 2'd2) q_mem_q[wr_q + QPTR_W'(1)] <= push1;
	end

	// output side
	always_comb begin
		head          = q_mem_q[rd_q];
		m_axis_tvalid = (cnt_q != '0);
		m_axis_tdata  = {5'd0, head.error_code, head.length, head.op_second,
			head.op_first, head.value};
		m_axis_tuser  = head.kind;
		m_axis_tlast  = head.last;
	end

endmodule

@@ sim/lexer_token_checker.sv @@
// token checker for the preprocessor expression lexer: predicts tokens per character and compares
module lexer_token_checker #(
	parameter int MAX_TOKEN_LEN = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [63:0] m_axis_tdata,
	input  logic [2:0]  m_axis_tuser,
	input  logic        m_axis_tlast,
	output int          mismatches,
	output int          pending,
	output int          chars_lexed,
	output int          tokens_checked,
	output logic [7:0]  kinds_seen,
	output logic [5:0]  errors_seen
);
	import ppel_pkg::*;

	lex_state_t  lx_state;
	logic [31:0] acc;
	int          tok_len;
	logic        dq;
	logic [7:0]  plain_ch;
	logic        sharp_seen;
	logic [7:0]  angle_ch;
	base_t       radix;
	int          step_tokens;
	res_t        expected_tokens[$];
	int          bad_count;
	int          char_count;
	int          tok_count;
	logic [7:0]  kinds_hit;
	logic [5:0]  errors_hit;

	function automatic logic ch_eol(input logic [7:0] c);
		return c == 8'd0 || c == 8'd10;
	endfunction

	function automatic logic ch_blank(input logic [7:0] c);
		return c == 8'd32 || c == 8'd9 || c == 8'd11 || c == 8'd12 || c == 8'd13;
	endfunction

	function automatic logic ch_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic ch_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic ch_word(input logic [7:0] c);
		return ch_alpha(c) || ch_digit(c) || c == "_";
	endfunction

	function automatic logic ch_hex(input logic [7:0] c);
		return ch_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	function automatic logic ch_long(input logic [7:0] c);
		return c == "l" || c == "L";
	endfunction

	function automatic logic ch_unsigned(input logic [7:0] c);
		return c == "u" || c == "U";
	endfunction

	function automatic logic [3:0] hex_digit_val(input logic [7:0] c);
		if (ch_digit(c)) return 4'(c - 8'h30);
		if (c >= "a") return 4'(c - "a" + 8'd10);
		return 4'(c - "A" + 8'd10);
	endfunction

	function automatic void grow();
		if (tok_len < MAX_TOKEN_LEN) tok_len++;
	endfunction

	function automatic void add_digit(input logic [3:0] d);
		logic [31:0] m;
		m = (radix == BASE_HEX) ? 32'd16 : (radix == BASE_OCT) ? 32'd8 : 32'd10;
		acc = acc * m + {28'd0, d};
		grow();
	endfunction

	// every token ends the current one, so the lexer goes back to its initial state
	function automatic void push_token(input kind_t k, input logic [31:0] v, input logic [7:0] a,
			input logic [7:0] b, input int len, input err_t e);
		res_t r;
		r.kind       = k;
		r.value      = v;
		r.op_first   = a;
		r.op_second  = b;
		r.length     = (len > 255) ? 8'd255 : 8'(len);
		r.error_code = e;
		r.last       = 1'b0;
		expected_tokens.push_back(r);
		step_tokens++;
		lx_state = ST_INIT;
	endfunction

	function automatic void fail_token(input err_t e);
		push_token(KIND_ERROR, 32'd0, 8'd0, 8'd0, 0, e);
	endfunction

	function automatic void number_token();
		push_token(KIND_NUMBER, acc, 8'd0, 8'd0, tok_len, ERR_NONE);
	endfunction

	function automatic void op_token(input logic [7:0] a, input logic [7:0] b);
		push_token(KIND_OP, 32'd0, a, b, (b == 8'd0) ? 1 : 2, ERR_NONE);
	endfunction

	function automatic void token_start(input logic [7:0] c, input logic sharp);
		if (ch_eol(c)) begin
			push_token(KIND_EOL, 32'd0, 8'd0, 8'd0, 0, ERR_NONE);
			return;
		end
		if (ch_blank(c)) return;
		tok_len = 0;
		acc = '0;
		if (ch_alpha(c) || c == "_" || c == "#") begin
			grow();
			sharp_seen = (c == "#");
			lx_state = sharp ? ST_IDENT2 : ST_IDENT;
		end else if (c == "0") begin
			grow();
			radix = BASE_DEC;
			lx_state = ST_NUM0;
		end else if (ch_digit(c)) begin
			radix = BASE_DEC;
			add_digit(4'(c - 8'h30));
			lx_state = ST_DEC;
		end else if (c == "|") lx_state = ST_VBAR;
		else if (c == "&") lx_state = ST_AND;
		else if (c == "!") lx_state = ST_NOT;
		else if (c == "=") lx_state = ST_EQ;
		else if (c == "<" || c == ">") begin
			angle_ch = c;
			lx_state = ST_ANGLE;
		end else if (c == "+") lx_state = ST_ADD;
		else if (c == "-") lx_state = ST_SUB;
		else if (c == "\"" || c == "'") begin
			grow();
			dq = (c == "\"");
			plain_ch = 8'hFF;
			lx_state = ST_STRING;
		end else op_token(c, 8'd0);
	endfunction

	// a character inside quotes; only the matching quote closes the literal
	function automatic void quoted_char(input logic [7:0] c);
		logic [31:0] v;
		lx_state = ST_STRING;
		grow();
		if (c == "\"") begin
			if (dq) push_token(KIND_STRING, 32'd0, 8'd0, 8'd0, tok_len, ERR_NONE);
		end else if (c == "'") begin
			if (!dq) begin
				v = {{24{plain_ch[7]}}, plain_ch};
				push_token(KIND_CHAR, v, 8'd0, 8'd0, tok_len, ERR_NONE);
			end
		end else if (c == "\\") lx_state = ST_ESC;
		else plain_ch = c;
	endfunction

	// returns 1 when the character ends the token and has to start a new one
	function automatic bit continue_token(input logic [7:0] c);
		case (lx_state)
		ST_IDENT: begin
			if (ch_word(c)) begin
				grow();
				return 1'b0;
			end
			push_token(KIND_IDENT, 32'd0, 8'd0, 8'd0, tok_len, ERR_NONE);
			return 1'b1;
		end
		ST_IDENT2: begin
			if (ch_blank(c)) return 1'b0;
			if (ch_word(c) || c == "#") begin
				if (c == "#") sharp_seen = 1'b1;
				grow();
				return 1'b0;
			end
			push_token(sharp_seen ? KIND_MACRO : KIND_IDENT, 32'd0, 8'd0, 8'd0, tok_len,
				ERR_NONE);
			return 1'b1;
		end
		ST_NUM0: begin
			if (c == "x" || c == "X") begin
				grow();
				lx_state = ST_0X;
				return 1'b0;
			end
			if (c >= "0" && c <= "7") begin
				radix = BASE_OCT;
				add_digit(4'(c - 8'h30));
				lx_state = ST_OCT;
				return 1'b0;
			end
			if (c == "8" || c == "9") begin
				fail_token(ERR_DIGIT89);
				return 1'b0;
			end
			number_token();
			return 1'b1;
		end
		ST_OCT: begin
			if (c >= "0" && c <= "7") begin
				add_digit(4'(c - 8'h30));
				return 1'b0;
			end
			number_token();
			return 1'b1;
		end
		ST_0X: begin
			if (ch_hex(c)) begin
				radix = BASE_HEX;
				add_digit(hex_digit_val(c));
				lx_state = ST_HEX;
				return 1'b0;
			end
			fail_token(ERR_BARE_0X);
			return ch_eol(c);
		end
		ST_HEX, ST_DEC: begin
			if (lx_state == ST_HEX ? ch_hex(c) : ch_digit(c)) begin
				add_digit(hex_digit_val(c));
				return 1'b0;
			end
			if (ch_unsigned(c)) begin
				lx_state = ST_POST1;
				return 1'b0;
			end
			if (ch_long(c)) begin
				lx_state = ST_POST2;
				return 1'b0;
			end
			number_token();
			return 1'b1;
		end
		ST_POST1: begin
			if (ch_long(c)) begin
				lx_state = ST_POST2;
				return 1'b0;
			end
			number_token();
			return 1'b1;
		end
		ST_POST2: begin
			number_token();
			return !ch_long(c);
		end
		ST_VBAR: begin
			if (c == "|") begin
				op_token("|", "|");
				return 1'b0;
			end
			op_token("|", 8'd0);
			return 1'b1;
		end
		ST_AND: begin
			if (c == "&") begin
				op_token("&", "&");
				return 1'b0;
			end
			op_token("&", 8'd0);
			return 1'b1;
		end
		ST_NOT: begin
			if (c == "=") begin
				op_token("!", "=");
				return 1'b0;
			end
			op_token("!", 8'd0);
			return 1'b1;
		end
		ST_EQ: begin
			if (c == "=") begin
				op_token("=", "=");
				return 1'b0;
			end
			op_token("=", 8'd0);
			return 1'b1;
		end
		ST_ANGLE: begin
			if (c == "=" || c == angle_ch) begin
				op_token(angle_ch, c);
				return 1'b0;
			end
			op_token(angle_ch, 8'd0);
			return 1'b1;
		end
		ST_ADD: begin
			if (c == "+") begin
				fail_token(ERR_INC);
				return 1'b0;
			end
			op_token("+", 8'd0);
			return 1'b1;
		end
		ST_SUB: begin
			if (c == "-") begin
				fail_token(ERR_DEC);
				return 1'b0;
			end
			op_token("-", 8'd0);
			return 1'b1;
		end
		ST_STRING, ST_ESC, ST_STRHEX: begin
			// the line end inside quotes is an error and then an end of line
			if (ch_eol(c)) begin
				fail_token(ERR_UNTERM);
				return 1'b1;
			end
			if (lx_state == ST_ESC) begin
				grow();
				lx_state = (c == "x" || c == "X") ? ST_STRHEX : ST_STRING;
			end else if (lx_state == ST_STRHEX && ch_hex(c)) grow();
			else quoted_char(c);
			return 1'b0;
		end
		default: begin
			lx_state = ST_INIT;
			return 1'b1;
		end
		endcase
	endfunction

	function automatic void lex_char(input logic [7:0] c, input logic sharp);
		res_t r;
		step_tokens = 0;
		if (lx_state == ST_INIT) token_start(c, sharp);
		else if (continue_token(c)) begin
			lx_state = ST_INIT;
			token_start(c, sharp);
		end
		if (step_tokens > 0) begin
			r = expected_tokens.pop_back();
			r.last = 1'b1;
			expected_tokens.push_back(r);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			lx_state = ST_INIT;
			acc = '0;
			tok_len = 0;
			dq = 1'b0;
			plain_ch = 8'hFF;
			sharp_seen = 1'b0;
			angle_ch = 8'd0;
			radix = BASE_DEC;
			expected_tokens.delete();
			bad_count = 0;
			char_count = 0;
			tok_count = 0;
			kinds_hit = '0;
			errors_hit = '0;
			mismatches <= 0;
			pending <= 0;
			chars_lexed <= 0;
			tokens_checked <= 0;
			kinds_seen <= '0;
			errors_seen <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				lex_char(s_axis_tdata[7:0], s_axis_tdata[8]);
				char_count++;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				tok_count++;
				if (expected_tokens.size() == 0) begin
					$error("token with none expected: kind %0d value %h op %h %h length %0d error %0d",
						m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[39:32],
						m_axis_tdata[47:40], m_axis_tdata[55:48], m_axis_tdata[58:56]);
					bad_count++;
				end else begin
					want = expected_tokens.pop_front();
					kinds_hit[want.kind] = 1'b1;
					errors_hit[want.error_code] = 1'b1;
					if (m_axis_tuser !== want.kind) begin
						$error("kind: expected %0d, got %0d", want.kind, m_axis_tuser);
						bad_count++;
					end
					if (m_axis_tdata[31:0] !== want.value) begin
						$error("value: expected %h, got %h", want.value, m_axis_tdata[31:0]);
						bad_count++;
					end
					if (m_axis_tdata[39:32] !== want.op_first) begin
						$error("op_first: expected %h, got %h", want.op_first,
							m_axis_tdata[39:32]);
						bad_count++;
					end
					if (m_axis_tdata[47:40] !== want.op_second) begin
						$error("op_second: expected %h, got %h", want.op_second,
							m_axis_tdata[47:40]);
						bad_count++;
					end
					if (m_axis_tdata[55:48] !== want.length) begin
						$error("length: expected %0d, got %0d", want.length, m_axis_tdata[55:48]);
						bad_count++;
					end
					if (m_axis_tdata[58:56] !== want.error_code) begin
						$error("error_code: expected %0d, got %0d", want.error_code,
							m_axis_tdata[58:56]);
						bad_count++;
					end
					if (m_axis_tlast !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, m_axis_tlast);
						bad_count++;
					end
				end
			end
			mismatches <= bad_count;
			pending <= expected_tokens.size();
			chars_lexed <= char_count;
			tokens_checked <= tok_count;
			kinds_seen <= kinds_hit;
			errors_seen <= errors_hit;
		end
	end

endmodule

@@ sim/preprocessor_expression_lexer_tb.sv @@
// testbench top for the preprocessor expression lexer: character stimulus and verdict
module preprocessor_expression_lexer_tb;

	// generous bound: every character with a long gap and two tokens that each wait out
	// a long stall stays far below it
	localparam int CYCLE_LIMIT  = 500000;
	localparam int RANDOM_CHARS = 200;
	// a token passes the input register and the result queue, so a drain wait settles the tail
	localparam int DRAIN_CYCLES = 8;

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata  = '0;   // ch [7:0], get_sharp [8], zero [15:9]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;         // value [31:0], op_first [39:32], op_second [47:40],
	                                   // length [55:48], error_code [58:56], zero [63:59]
	logic [2:0]  m_axis_tuser;         // kind [2:0]
	logic        m_axis_tlast;

	int          mismatches;
	int          pending;
	int          chars_lexed;
	int          tokens_checked;
	logic [7:0]  kinds_seen;
	logic [5:0]  errors_seen;

	// idling modes, changed per line: 0 means no gaps or no stalls at all
	int          gap_mode    = 0;
	int          sink_mode   = 0;
	int          stall_left  = 0;
	int          cycle_count = 0;
	int          chars_sent  = 0;

	preprocessor_expression_lexer uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	lexer_token_checker token_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.m_axis_tuser   (m_axis_tuser),
		.m_axis_tlast   (m_axis_tlast),
		.mismatches     (mismatches),
		.pending        (pending),
		.chars_lexed    (chars_lexed),
		.tokens_checked (tokens_checked),
		.kinds_seen     (kinds_seen),
		.errors_seen    (errors_seen)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d tokens still expected", cycle_count, pending);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// token sink: mostly ready, short stalls now and then, rarely a long one
	initial begin
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else if (sink_mode != 0 && $urandom_range(0, 99) < 20) begin
				stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
					: $urandom_range(0, 3);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	function automatic int pick_gap();
		int r;
		if (gap_mode == 0) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] pick_from(input string s);
		return s[$urandom_range(0, s.len() - 1)];
	endfunction

	function automatic logic [7:0] random_blank();
		case ($urandom_range(0, 5))
		0: return 8'd9;
		1: return 8'd11;
		2: return 8'd12;
		3: return 8'd13;
		default: return 8'd32;
		endcase
	endfunction

	// one item: optional gap, then hold valid until the lexer takes it;
	// valid stays high between back-to-back items
	task automatic send_char(input logic [7:0] c, input logic sharp);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {7'd0, sharp, c};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		chars_sent++;
	endtask

	task automatic send_text(input string s, input logic sharp);
		for (int i = 0; i < s.len(); i++) send_char(s[i], sharp);
	endtask

	// number suffixes, including runs the lexer only partly takes
	task automatic send_suffix(input logic sharp);
		case ($urandom_range(0, 11))
		4: send_text("u", sharp);
		5: send_text("U", sharp);
		6: send_text("l", sharp);
		7: send_text("uL", sharp);
		8: send_text("LL", sharp);
		9: send_text("ull", sharp);
		10: send_text("lu", sharp);
		11: send_text("lll", sharp);
		default: ;
		endcase
	endtask

	// one random token, mostly well formed with random content
	task automatic send_token();
		int pick;
		int n;
		logic sh;
		logic [7:0] q;
		sh = 1'($urandom_range(0, 1));
		pick = $urandom_range(0, 99);
		if (pick < 16) begin
			// identifier; in sharp mode a '#' or blanks may sit inside it
			send_char(pick_from("abzAZ_#LuxX"), sh);
			repeat ($urandom_range(0, 6)) begin
				if (sh && $urandom_range(0, 3) == 0)
					send_char($urandom_range(0, 1) ? 8'h23 : random_blank(), sh);
				else
					send_char(pick_from("azAZ_09lUx"), sh);
			end
		end else if (pick < 30) begin
			// decimal, long runs wrap modulo 2^32
			send_char(pick_from("123456789"), sh);
			repeat ($urandom_range(0, 11)) send_char(pick_from("0123456789"), sh);
			send_suffix(sh);
		end else if (pick < 38) begin
			// octal, now and then a stray 8 or 9
			send_char("0", sh);
			repeat ($urandom_range(0, 11)) send_char(pick_from("01234567"), sh);
			if ($urandom_range(0, 5) == 0) send_char(pick_from("89"), sh);
		end else if (pick < 50) begin
			// hex; with no digit it is the bare 0x error
			send_char("0", sh);
			send_char(pick_from("xX"), sh);
			repeat ($urandom_range(0, 9)) send_char(pick_from("0123456789abcdefABCDEF"), sh);
			send_suffix(sh);
		end else if (pick < 54) begin
			// a lone zero ends before a suffix letter
			send_char("0", sh);
			send_char(pick_from("uUlL"), sh);
		end else if (pick < 76) begin
			// one- and two-character operators, ++ and -- among them
			send_char(pick_from("|&!=<>+-*/%()?:~^,."), sh);
			if ($urandom_range(0, 1)) send_char(pick_from("|&=<>+-"), sh);
		end else if (pick < 92) begin
			// string or char literal with plain, high and escaped characters
			q = pick_from("\"'");
			send_char(q, sh);
			repeat ($urandom_range(0, 5)) begin
				n = $urandom_range(0, 9);
				if (n < 5) send_char(8'($urandom_range(32, 126)), sh);
				else if (n < 6) send_char(8'($urandom_range(128, 255)), sh);
				else if (n < 8) begin
					send_char("\\", sh);
					send_char(pick_from("xXn\"'\\q"), sh);
				end else begin
					send_char("\\", sh);
					send_char("x", sh);
					repeat ($urandom_range(0, 3)) send_char(pick_from("09afAF"), sh);
				end
			end
			// now and then left open until the line ends
			if ($urandom_range(0, 7) != 0) send_char(q, sh);
		end else begin
			// noise: any code at all
			send_char(8'($urandom_range(0, 255)), sh);
		end
	endtask

	initial begin
		int random_start;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: both extreme codes, macro string across a blank, ++, 0 then 9,
		// bare 0x, --, char literal with a hex escape closed by a plain char,
		// << then =, an operator right before a quote, unterminated string
		gap_mode = 1;
		sink_mode = 1;
		send_char(8'h00, 1'b0);
		send_char(8'hFF, 1'b1);
		send_text("# a++090xg--'\\x41q'<<=\"ab", 1'b1);
		send_char(8'd10, 1'b0);

		// one long identifier so the length saturates
		repeat (258) send_char("a", 1'b0);
		send_char(8'd10, 1'b0);

		// random lines of tokens, idling modes changed per line
		random_start = chars_sent;
		while (chars_sent - random_start < RANDOM_CHARS) begin
			gap_mode = $urandom_range(0, 2);
			sink_mode = $urandom_range(0, 2);
			repeat ($urandom_range(1, 8)) begin
				if ($urandom_range(0, 2) == 0)
					send_char(random_blank(), 1'($urandom_range(0, 1)));
				send_token();
			end
			send_char($urandom_range(0, 3) == 0 ? 8'd0 : 8'd10, 1'($urandom_range(0, 1)));
		end

		s_axis_tvalid <= 1'b0;
		gap_mode = 0;
		sink_mode = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d characters lexed into %0d tokens", chars_lexed, tokens_checked);
		$display("token kinds seen %b, error codes seen %b", kinds_seen, errors_seen);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
